@@ hw/rtl/pdjlq_pkg.sv @@
// ----------------------------------------------------------------------------
// pdjlq_pkg
// Shared types, codes and the random generator step of the impairment queue.
// ----------------------------------------------------------------------------
package pdjlq_pkg;

  localparam int unsigned TIME_W   = 48;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned LOSS_MOD = 100;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_QUEUED  = 3'd0,
    STATUS_LOST    = 3'd1,
    STATUS_FULL    = 3'd2,
    STATUS_TOOLONG = 3'd3,
    STATUS_NONE    = 3'd4,
    STATUS_BYTE    = 3'd5,
    STATUS_DISCARD = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    REG_LOSS   = 2'd0,
    REG_LAG    = 2'd1,
    REG_JITTER = 2'd2,
    REG_SEED   = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_MOD, ST_MDONE, ST_FULL, ST_DELAY, ST_DUE, ST_RESULT,
    ST_SCAN, ST_CMP, ST_RDB, ST_EMIT, ST_RM_RD, ST_RM_WR, ST_CP_RD, ST_CP_WR,
    ST_MVCHK, ST_MV_RD, ST_MV_WR, ST_DONE
  } state_t;

  function automatic logic [31:0] xorshift(input logic [31:0] s);
    logic [31:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

@@ hw/rtl/packet_delay_jitter_loss_queue.sv @@
// ----------------------------------------------------------------------------
// packet_delay_jitter_loss_queue
// Delay, jitter and loss queue for packets that arrive one byte per item.
// ----------------------------------------------------------------------------
// A byte item that is not last is stored and the block stays idle. A last
// byte may go through a loss draw and a jitter draw (one 32-step remainder
// unit serves both draws). A poll scans the due times entry by entry, emits
// each byte through the single payload read port, and a removal copies a
// whole slot byte by byte, then moves any packet still being assembled byte
// by byte. The block takes no item while it works on one.
module packet_delay_jitter_loss_queue #(
  parameter int unsigned QUEUE_DEPTH  = 256,
  parameter int unsigned PACKET_BYTES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_last_byte,
  input  logic [pdjlq_pkg::TIME_W-1:0]        in_time_ms,
  input  logic [pdjlq_pkg::LEN_W-1:0]         in_capacity,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pdjlq_pkg::STATUS_W-1:0]      out_status,
  output logic [7:0]                          out_byte,
  output logic                                out_last,
  output logic [pdjlq_pkg::LEN_W-1:0]         out_packet_length,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [pdjlq_pkg::CFG_W-1:0]         cfg_data
);

  localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QAW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned AW   = $clog2(PACKET_BYTES + 1);
  localparam int unsigned MD   = QUEUE_DEPTH * PACKET_BYTES;
  localparam int unsigned MAW  = (MD > 1) ? $clog2(MD) : 1;
  localparam int unsigned TW   = pdjlq_pkg::TIME_W;
  localparam int unsigned LW   = pdjlq_pkg::LEN_W;

  logic [TW-1:0]  due_mem [QUEUE_DEPTH];
  logic [AW-1:0]  len_mem [QUEUE_DEPTH];
  logic [7:0]     pay_mem [MD];

  pdjlq_pkg::state_t state_r, state_nxt;

  logic [6:0]   loss_r, loss_nxt;
  logic [15:0]  lag_r, lag_nxt;
  logic [14:0]  jit_r, jit_nxt;
  logic [31:0]  rng_r, rng_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] asm_r, asm_nxt;
  logic         ovf_r, ovf_nxt;
  logic         plost_r, plost_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [AW-1:0] plen_r, plen_nxt;
  logic         poll_r, poll_nxt;
  logic [TW-1:0] now_r, now_nxt;
  logic [LW-1:0] cap_r, cap_nxt;
  logic [2:0]   res_st_r, res_st_nxt;
  logic [LW-1:0] res_len_r, res_len_nxt;
  logic [17:0]  d_r, d_nxt;
  logic [31:0]  mq_r, mq_nxt;
  logic [15:0]  mrem_r, mrem_nxt;
  logic [15:0]  mdiv_r, mdiv_nxt;
  logic [4:0]   mcnt_r, mcnt_nxt;
  logic         mloss_r, mloss_nxt;

  logic         ov_r, ov_nxt;
  logic [2:0]   ost_r, ost_nxt;
  logic [7:0]   ob_r, ob_nxt;
  logic         ol_r, ol_nxt;
  logic [LW-1:0] olen_r, olen_nxt;

  logic [TW-1:0] due_rd_r;
  logic [AW-1:0] len_rd_r;
  logic [7:0]    pay_rd_r;

  logic          due_we, pay_we;
  logic [QAW-1:0] due_waddr, due_raddr;
  logic [TW-1:0] due_wdata;
  logic [AW-1:0] len_wdata;
  logic [MAW-1:0] pay_waddr, pay_raddr;
  logic [7:0]    pay_wdata;

  logic          out_free;
  logic [CW-1:0] last_idx;
  logic [16:0]   mtrial;
  logic [18:0]   dsum;
  logic [31:0]   drawn;

  function automatic logic [MAW-1:0] paddr(input logic [QAW-1:0] slot,
                                           input logic [AW-1:0] k);
    return MAW'(MAW'(slot) * MAW'(PACKET_BYTES) + MAW'(k));
  endfunction

  assign out_free = !ov_r || out_ready;
  assign last_idx = count_r - CW'(1);
  assign mtrial   = {mrem_r, mq_r[31]};
  assign dsum     = {3'b000, lag_r} + {3'b000, mrem_r} - {4'b0000, jit_r};
  assign drawn    = pdjlq_pkg::xorshift(rng_r);

  always_ff @(posedge clk) begin
    if (due_we) begin
      due_mem[due_waddr] <= due_wdata;
      len_mem[due_waddr] <= len_wdata;
    end
    due_rd_r <= due_mem[due_raddr];
    len_rd_r <= len_mem[due_raddr];
    if (pay_we) begin
      pay_mem[pay_waddr] <= pay_wdata;
    end
    pay_rd_r <= pay_mem[pay_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdjlq_pkg::ST_IDLE;
      loss_r  <= '0;
      lag_r   <= '0;
      jit_r   <= '0;
      rng_r   <= 32'd1;
      count_r <= '0;
      asm_r   <= '0;
      ovf_r   <= 1'b0;
      plost_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      loss_r  <= loss_nxt;
      lag_r   <= lag_nxt;
      jit_r   <= jit_nxt;
      rng_r   <= rng_nxt;
      count_r <= count_nxt;
      asm_r   <= asm_nxt;
      ovf_r   <= ovf_nxt;
      plost_r <= plost_nxt;
      ov_r    <= ov_nxt;
    end
    idx_r     <= idx_nxt;
    k_r       <= k_nxt;
    plen_r    <= plen_nxt;
    poll_r    <= poll_nxt;
    now_r     <= now_nxt;
    cap_r     <= cap_nxt;
    res_st_r  <= res_st_nxt;
    res_len_r <= res_len_nxt;
    d_r       <= d_nxt;
    mq_r      <= mq_nxt;
    mrem_r    <= mrem_nxt;
    mdiv_r    <= mdiv_nxt;
    mcnt_r    <= mcnt_nxt;
    mloss_r   <= mloss_nxt;
    ost_r     <= ost_nxt;
    ob_r      <= ob_nxt;
    ol_r      <= ol_nxt;
    olen_r    <= olen_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    loss_nxt    = loss_r;
    lag_nxt     = lag_r;
    jit_nxt     = jit_r;
    rng_nxt     = rng_r;
    count_nxt   = count_r;
    asm_nxt     = asm_r;
    ovf_nxt     = ovf_r;
    plost_nxt   = plost_r;
    idx_nxt     = idx_r;
    k_nxt       = k_r;
    plen_nxt    = plen_r;
    poll_nxt    = poll_r;
    now_nxt     = now_r;
    cap_nxt     = cap_r;
    res_st_nxt  = res_st_r;
    res_len_nxt = res_len_r;
    d_nxt       = d_r;
    mq_nxt      = mq_r;
    mrem_nxt    = mrem_r;
    mdiv_nxt    = mdiv_r;
    mcnt_nxt    = mcnt_r;
    mloss_nxt   = mloss_r;
    ov_nxt      = ov_r && !out_ready;
    ost_nxt     = ost_r;
    ob_nxt      = ob_r;
    ol_nxt      = ol_r;
    olen_nxt    = olen_r;
    in_ready    = 1'b0;
    due_we      = 1'b0;
    due_waddr   = count_r[QAW-1:0];
    due_raddr   = idx_r[QAW-1:0];
    due_wdata   = now_r + TW'(d_r);
    len_wdata   = asm_r;
    pay_we      = 1'b0;
    pay_waddr   = paddr(count_r[QAW-1:0], asm_r);
    pay_wdata   = in_data_byte;
    pay_raddr   = paddr(idx_r[QAW-1:0], k_r);

    unique case (state_r)
      pdjlq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          poll_nxt = in_command;
          now_nxt  = in_time_ms;
          cap_nxt  = in_capacity;
          if (in_command) begin
            idx_nxt   = '0;
            state_nxt = pdjlq_pkg::ST_SCAN;
          end else begin
            if (asm_r < AW'(PACKET_BYTES)) begin
              if (count_r < CW'(QUEUE_DEPTH)) begin
                pay_we = 1'b1;
              end else begin
                plost_nxt = 1'b1;
              end
              asm_nxt = asm_r + AW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
            if (in_last_byte) begin
              state_nxt = pdjlq_pkg::ST_CHECK;
            end
          end
        end
      end
      pdjlq_pkg::ST_CHECK: begin
        res_len_nxt = LW'(asm_r);
        if (ovf_r) begin
          res_st_nxt = pdjlq_pkg::STATUS_TOOLONG;
          state_nxt  = pdjlq_pkg::ST_RESULT;
        end else if (loss_r != '0) begin
          rng_nxt   = drawn;
          mq_nxt    = drawn;
          mrem_nxt  = '0;
          mcnt_nxt  = '0;
          mdiv_nxt  = 16'(pdjlq_pkg::LOSS_MOD);
          mloss_nxt = 1'b1;
          state_nxt = pdjlq_pkg::ST_MOD;
        end else begin
          state_nxt = pdjlq_pkg::ST_FULL;
        end
      end
      pdjlq_pkg::ST_MOD: begin
        mq_nxt   = {mq_r[30:0], 1'b0};
        mrem_nxt = (mtrial >= {1'b0, mdiv_r}) ? 16'(mtrial - {1'b0, mdiv_r})
                                               : mtrial[15:0];
        mcnt_nxt = mcnt_r + 5'd1;
        if (mcnt_r == 5'd31) begin
          state_nxt = pdjlq_pkg::ST_MDONE;
        end
      end
      pdjlq_pkg::ST_MDONE: begin
        if (mloss_r) begin
          if (mrem_r < {9'd0, loss_r}) begin
            res_st_nxt = pdjlq_pkg::STATUS_LOST;
            state_nxt  = pdjlq_pkg::ST_RESULT;
          end else begin
            state_nxt = pdjlq_pkg::ST_FULL;
          end
        end else begin
          state_nxt = pdjlq_pkg::ST_DELAY;
        end
      end
      pdjlq_pkg::ST_FULL: begin
        if (count_r >= CW'(QUEUE_DEPTH) || plost_r) begin
          res_st_nxt = pdjlq_pkg::STATUS_FULL;
          state_nxt  = pdjlq_pkg::ST_RESULT;
        end else if (jit_r != '0) begin
          rng_nxt   = drawn;
          mq_nxt    = drawn;
          mrem_nxt  = '0;
          mcnt_nxt  = '0;
          mdiv_nxt  = {jit_r, 1'b1};
          mloss_nxt = 1'b0;
          state_nxt = pdjlq_pkg::ST_MOD;
        end else begin
          d_nxt     = {2'b00, lag_r};
          state_nxt = pdjlq_pkg::ST_DUE;
        end
      end
      pdjlq_pkg::ST_DELAY: begin
        d_nxt     = dsum[18] ? '0 : dsum[17:0];
        state_nxt = pdjlq_pkg::ST_DUE;
      end
      pdjlq_pkg::ST_DUE: begin
        due_we     = 1'b1;
        count_nxt  = count_r + CW'(1);
        res_st_nxt = pdjlq_pkg::STATUS_QUEUED;
        state_nxt  = pdjlq_pkg::ST_RESULT;
      end
      pdjlq_pkg::ST_RESULT: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          ost_nxt  = res_st_r;
          ob_nxt   = '0;
          ol_nxt   = 1'b1;
          olen_nxt = res_len_r;
          if (poll_r) begin
            state_nxt = (res_st_r == pdjlq_pkg::STATUS_DISCARD) ? pdjlq_pkg::ST_RM_RD
                                                                : pdjlq_pkg::ST_IDLE;
          end else begin
            asm_nxt   = '0;
            ovf_nxt   = 1'b0;
            plost_nxt = 1'b0;
            state_nxt = pdjlq_pkg::ST_IDLE;
          end
        end
      end
      pdjlq_pkg::ST_SCAN: begin
        if (idx_r >= count_r) begin
          res_st_nxt  = pdjlq_pkg::STATUS_NONE;
          res_len_nxt = '0;
          state_nxt   = pdjlq_pkg::ST_RESULT;
        end else begin
          state_nxt = pdjlq_pkg::ST_CMP;
        end
      end
      pdjlq_pkg::ST_CMP: begin
        if (due_rd_r <= now_r) begin
          plen_nxt    = len_rd_r;
          res_len_nxt = LW'(len_rd_r);
          k_nxt       = '0;
          if (LW'(len_rd_r) > cap_r) begin
            res_st_nxt = pdjlq_pkg::STATUS_DISCARD;
            state_nxt  = pdjlq_pkg::ST_RESULT;
          end else if (len_rd_r == '0) begin
            state_nxt = pdjlq_pkg::ST_RM_RD;
          end else begin
            state_nxt = pdjlq_pkg::ST_RDB;
          end
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = pdjlq_pkg::ST_SCAN;
        end
      end
      pdjlq_pkg::ST_RDB: begin
        state_nxt = pdjlq_pkg::ST_EMIT;
      end
      pdjlq_pkg::ST_EMIT: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          ost_nxt  = pdjlq_pkg::STATUS_BYTE;
          ob_nxt   = pay_rd_r;
          ol_nxt   = ((k_r + AW'(1)) == plen_r);
          olen_nxt = LW'(plen_r);
          k_nxt    = k_r + AW'(1);
          state_nxt = ((k_r + AW'(1)) == plen_r) ? pdjlq_pkg::ST_RM_RD
                                                 : pdjlq_pkg::ST_RDB;
        end
      end
      pdjlq_pkg::ST_RM_RD: begin
        due_raddr = last_idx[QAW-1:0];
        k_nxt     = '0;
        state_nxt = (idx_r == last_idx) ? pdjlq_pkg::ST_MVCHK : pdjlq_pkg::ST_RM_WR;
      end
      pdjlq_pkg::ST_RM_WR: begin
        due_we    = 1'b1;
        due_waddr = idx_r[QAW-1:0];
        due_wdata = due_rd_r;
        len_wdata = len_rd_r;
        state_nxt = pdjlq_pkg::ST_CP_RD;
      end
      pdjlq_pkg::ST_CP_RD: begin
        pay_raddr = paddr(last_idx[QAW-1:0], k_r);
        state_nxt = pdjlq_pkg::ST_CP_WR;
      end
      pdjlq_pkg::ST_CP_WR: begin
        pay_we    = 1'b1;
        pay_waddr = paddr(idx_r[QAW-1:0], k_r);
        pay_wdata = pay_rd_r;
        k_nxt     = k_r + AW'(1);
        state_nxt = (k_r == AW'(PACKET_BYTES - 1)) ? pdjlq_pkg::ST_MVCHK
                                                   : pdjlq_pkg::ST_CP_RD;
      end
      pdjlq_pkg::ST_MVCHK: begin
        k_nxt = '0;
        if (asm_r != '0 && !plost_r && count_r < CW'(QUEUE_DEPTH)) begin
          state_nxt = pdjlq_pkg::ST_MV_RD;
        end else begin
          state_nxt = pdjlq_pkg::ST_DONE;
        end
      end
      pdjlq_pkg::ST_MV_RD: begin
        pay_raddr = paddr(count_r[QAW-1:0], k_r);
        state_nxt = pdjlq_pkg::ST_MV_WR;
      end
      pdjlq_pkg::ST_MV_WR: begin
        pay_we    = 1'b1;
        pay_waddr = paddr(last_idx[QAW-1:0], k_r);
        pay_wdata = pay_rd_r;
        k_nxt     = k_r + AW'(1);
        state_nxt = ((k_r + AW'(1)) == asm_r) ? pdjlq_pkg::ST_DONE : pdjlq_pkg::ST_MV_RD;
      end
      pdjlq_pkg::ST_DONE: begin
        count_nxt = last_idx;
        state_nxt = pdjlq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pdjlq_pkg::ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (pdjlq_pkg::reg_idx_t'(cfg_index))
        pdjlq_pkg::REG_LOSS:   loss_nxt = cfg_data[6:0];
        pdjlq_pkg::REG_LAG:    lag_nxt  = cfg_data[15:0];
        pdjlq_pkg::REG_JITTER: jit_nxt  = cfg_data[14:0];
        pdjlq_pkg::REG_SEED:   rng_nxt  = (cfg_data == '0) ? 32'd1 : cfg_data;
        default:               loss_nxt = loss_r;
      endcase
    end
  end

  assign out_valid         = ov_r;
  assign out_status        = ost_r;
  assign out_byte          = ob_r;
  assign out_last          = ol_r;
  assign out_packet_length = olen_r;

endmodule

@@ hw/rtl/pdjlq_checker.sv @@
// ----------------------------------------------------------------------------
// pdjlq_checker
// Port-level checks of the impairment queue, bound to the top level.
// ----------------------------------------------------------------------------
module pdjlq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_command,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic [6:0] out_packet_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_byte))
    else $error("result item changed while stalled");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != pdjlq_pkg::STATUS_BYTE |-> out_last && out_byte == 8'd0)
    else $error("single result item malformed");

  a_none_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pdjlq_pkg::STATUS_NONE |-> out_packet_length == 7'd0)
    else $error("none-due result carries a length");

  a_poll_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command |=> !in_ready)
    else $error("poll item did not hold off the next item");

endmodule

bind packet_delay_jitter_loss_queue pdjlq_checker u_pdjlq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_command        (in_command),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_byte          (out_byte),
  .out_last          (out_last),
  .out_packet_length (out_packet_length)
);

@@ sim/tb_packet_delay_jitter_loss_queue.sv @@
// ----------------------------------------------------------------------------
// tb_packet_delay_jitter_loss_queue
// Self-checking bench for the delay, jitter and loss queue. A predictor of
// the queue, its random generator and its slot reuse works out the results of
// every accepted item, and a checker compares each result field by field.
// ----------------------------------------------------------------------------
module tb_packet_delay_jitter_loss_queue;

  localparam int DEPTH = 256;
  localparam int PBYTES = 64;
  localparam int TIMEOUT = 200000;
  localparam logic [47:0] TMASK = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    pdjlq_pkg::status_t status;
    logic [7:0] data;
    logic       last;
    logic [6:0] length;
  } result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready;
  logic in_command = 0;
  logic [7:0] in_data_byte = 0;
  logic in_last_byte = 0;
  logic [47:0] in_time_ms = 0;
  logic [6:0] in_capacity = 0;
  logic out_valid, out_ready = 0;
  logic [2:0] out_status;
  logic [7:0] out_byte;
  logic out_last;
  logic [6:0] out_packet_length;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  packet_delay_jitter_loss_queue dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Predictor state.
  int unsigned p_loss, p_lag, p_jitter;
  logic [31:0] p_rng;
  int unsigned p_count, p_asm;
  bit p_overflow, p_part_lost;
  logic [47:0] p_due [DEPTH];
  int unsigned p_len [DEPTH];
  logic [7:0] p_store [DEPTH*PBYTES];

  result_t awaited[$];
  int mismatches = 0, results_seen = 0, items_sent = 0, idle_cycles = 0;
  int send_idle = 0, recv_idle = 0;
  logic [47:0] now_ms = 0;
  int delivered = 0, drops = 0;

  function automatic logic [31:0] next_draw();
    logic [31:0] x;
    x = p_rng;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    p_rng = x;
    return x;
  endfunction

  function automatic void expect_result(pdjlq_pkg::status_t s, logic [7:0] b, logic l,
                                        int unsigned n);
    result_t r;
    r.status = s; r.data = b; r.last = l; r.length = n[6:0];
    awaited.push_back(r);
  endfunction

  function automatic void drop_slot(int unsigned i);
    int unsigned n;
    n = p_count - 1;
    if (i != n) begin
      p_due[i] = p_due[n];
      p_len[i] = p_len[n];
      for (int k = 0; k < PBYTES; k++) p_store[i*PBYTES+k] = p_store[n*PBYTES+k];
    end
    if (p_asm > 0 && !p_part_lost && p_count < DEPTH)
      for (int k = 0; k < p_asm; k++) p_store[n*PBYTES+k] = p_store[p_count*PBYTES+k];
    p_count = n;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic l, logic [47:0] t);
    pdjlq_pkg::status_t s;
    int unsigned n, span;
    longint d;
    if (p_asm < PBYTES) begin
      if (p_count < DEPTH) p_store[p_count*PBYTES+p_asm] = b;
      else p_part_lost = 1;
      p_asm++;
    end else begin
      p_overflow = 1;
    end
    if (!l) return;
    n = p_asm;
    if (p_overflow) s = pdjlq_pkg::STATUS_TOOLONG;
    else if (p_loss > 0 && (next_draw() % 100) < p_loss) s = pdjlq_pkg::STATUS_LOST;
    else if (p_count >= DEPTH || p_part_lost) s = pdjlq_pkg::STATUS_FULL;
    else begin
      d = p_lag;
      if (p_jitter > 0) begin
        span = 2 * p_jitter + 1;
        d += longint'(next_draw() % span) - longint'(p_jitter);
      end
      if (d < 0) d = 0;
      p_due[p_count] = (t + 48'(d)) & TMASK;
      p_len[p_count] = n;
      p_count++;
      s = pdjlq_pkg::STATUS_QUEUED;
    end
    if (s != pdjlq_pkg::STATUS_QUEUED) drops++;
    p_asm = 0; p_overflow = 0; p_part_lost = 0;
    expect_result(s, 8'h00, 1'b1, n);
  endfunction

  function automatic void predict_poll(logic [47:0] t, int unsigned cap);
    logic [7:0] copy [PBYTES];
    int unsigned n;
    for (int unsigned i = 0; i < p_count; i++) begin
      if (p_due[i] <= t) begin
        n = p_len[i];
        if (n > cap) begin
          drop_slot(i);
          expect_result(pdjlq_pkg::STATUS_DISCARD, 8'h00, 1'b1, n);
          return;
        end
        for (int k = 0; k < PBYTES; k++) copy[k] = p_store[i*PBYTES+k];
        drop_slot(i);
        for (int unsigned k = 0; k < n; k++)
          expect_result(pdjlq_pkg::STATUS_BYTE, copy[k], k + 1 == n, n);
        delivered++;
        return;
      end
    end
    expect_result(pdjlq_pkg::STATUS_NONE, 8'h00, 1'b1, 0);
  endfunction

  task automatic write_reg(pdjlq_pkg::reg_idx_t idx, logic [31:0] v);
    in_valid <= 0;
    while (awaited.size() != 0 || !in_ready) @(negedge clk);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      pdjlq_pkg::REG_LOSS:   p_loss = v[6:0];
      pdjlq_pkg::REG_LAG:    p_lag = v[15:0];
      pdjlq_pkg::REG_JITTER: p_jitter = v[14:0];
      pdjlq_pkg::REG_SEED:   p_rng = (v == 0) ? 32'd1 : v;
    endcase
  endtask

  // Valid stays high after an accept so that a following item can go out
  // at once; anything that pauses the sender lowers it first.
  task automatic send_item(logic cmd, logic [7:0] b, logic l, logic [47:0] t, logic [6:0] cap);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; in_command <= cmd; in_data_byte <= b;
    in_last_byte <= l; in_time_ms <= t; in_capacity <= cap;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cmd) predict_poll(t, cap);
    else predict_byte(b, l, t);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet(int n, logic [47:0] t);
    for (int k = 0; k < n; k++) send_item(0, 8'($urandom), k == n - 1, t, 7'($urandom));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (awaited.size() != 0) @(negedge clk);
    repeat (4 * DEPTH + 8 * PBYTES) @(negedge clk);
  endtask

  always @(negedge clk) out_ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status %0d", out_status);
      end else begin
        e = awaited.pop_front();
        if (out_status !== e.status || out_byte !== e.data || out_last !== e.last ||
            out_packet_length !== e.length) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d b=%h l=%b n=%0d got st=%0d b=%h l=%b n=%0d",
                     e.status, e.data, e.last, e.length,
                     out_status, out_byte, out_last, out_packet_length);
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= TIMEOUT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_defaults();
    send_item(1, 0, 0, 0, 64);
    send_packet(1, 0);
    send_packet(3, 5);
    send_item(1, 8'hFF, 1, 10, 0);
    send_item(1, 0, 0, 10, 64);
    send_packet(5, 48'hFFFF_FFFF_FFFF);
    send_packet(65, 20);
    send_item(1, 0, 0, 48'hFFFF_FFFF_FFFF, 64);
    drain();
  endtask

  task automatic test_delay_and_loss();
    write_reg(pdjlq_pkg::REG_LAG, 16'hFFFF);
    write_reg(pdjlq_pkg::REG_JITTER, 15'h7FFF);
    write_reg(pdjlq_pkg::REG_SEED, 0);
    write_reg(pdjlq_pkg::REG_LOSS, 100);
    send_packet(2, 30);
    write_reg(pdjlq_pkg::REG_LOSS, 127);
    send_packet(1, 30);
    write_reg(pdjlq_pkg::REG_LOSS, 0);
    send_packet(2, 48'hFFFF_FFFF_0000);
    send_packet(2, 100);
    send_item(1, 0, 0, 200000, 64);
    send_item(1, 0, 0, 200000, 64);
    drain();
    write_reg(pdjlq_pkg::REG_LAG, 0);
    write_reg(pdjlq_pkg::REG_JITTER, 0);
    write_reg(pdjlq_pkg::REG_SEED, 32'hFFFF_FFFF);
  endtask

  task automatic test_random(int pieces);
    int r;
    repeat (pieces) begin
      now_ms = now_ms + $urandom_range(40);
      r = $urandom_range(99);
      if (r < 55) send_packet($urandom_range(1, 6), now_ms);
      else if (r < 60) send_item(0, 8'($urandom), 1'($urandom), now_ms, 7'($urandom));
      else send_item(1, 8'($urandom), 1'($urandom), now_ms,
                     7'($urandom_range(r < 65 ? 64 : 3, 0)));
    end
  endtask

  task automatic test_random_phases();
    now_ms = 48'h0000_8000_0000;
    write_reg(pdjlq_pkg::REG_LOSS, 20);
    write_reg(pdjlq_pkg::REG_LAG, 30);
    write_reg(pdjlq_pkg::REG_JITTER, 40);
    write_reg(pdjlq_pkg::REG_SEED, $urandom);
    send_idle = 38; recv_idle = 45;
    test_random(6);
    send_idle = 0; recv_idle = 0;
    // Hold off until the queue has answered everything so far.
    in_valid <= 0;
    while (awaited.size() != 0) @(negedge clk);
    send_idle = 45; recv_idle = 38;
    test_random(6);
    send_idle = 0; recv_idle = 0;
    test_random(6);
    now_ms = now_ms + 100000;
    repeat (10) send_item(1, 0, 0, now_ms, 64);
    drain();
  endtask

  initial begin
    p_loss = 0; p_lag = 0; p_jitter = 0; p_rng = 1;
    p_count = 0; p_asm = 0; p_overflow = 0; p_part_lost = 0;
    repeat (2) @(negedge clk);
    rst_n = 1;
    test_defaults();
    test_delay_and_loss();
    test_random_phases();
    $display("covered %0d items, %0d results, %0d packets delivered, %0d dropped",
             items_sent, results_seen, delivered, drops);
    $display("registers swept through extremes under mixed sender and receiver stalls");
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/pdjlq_pkg.sv
hw/rtl/packet_delay_jitter_loss_queue.sv
hw/rtl/pdjlq_checker.sv
sim/tb_packet_delay_jitter_loss_queue.sv
